[rtl/fud_pkg.sv]
// Package for the form body decoder: byte codes, result and state types,
// and the hex digit helper. No dependencies.
`default_nettype none

package fud_pkg;

	localparam logic [7:0] CharEq    = 8'h3D;
	localparam logic [7:0] CharAmp   = 8'h26;
	localparam logic [7:0] CharPlus  = 8'h2B;
	localparam logic [7:0] CharPct   = 8'h25;
	localparam logic [7:0] CharSpace = 8'h20;

	localparam int MaxResults = 4;
	localparam int ResIdxW    = $clog2(MaxResults);
	localparam int ResCntW    = $clog2(MaxResults + 1);

	typedef enum logic [1:0] {
		KIND_KEY      = 2'd0,
		KIND_VALUE    = 2'd1,
		KIND_PAIR_END = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       pair_kept;
		logic       run_last;
	} result_t;

	// All results caused by one input item, packed from index 0.
	typedef struct packed {
		logic [ResCntW-1:0]             count;
		result_t [MaxResults-1:0]       res;
	} res_set_t;

	typedef struct packed {
		logic       value_part;
		logic       key_seen;
		logic [1:0] held_count;
		logic [7:0] held_byte;
	} dec_state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		logic [7:0] d;
		h.ok = 1'b0;
		d    = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok = 1'b1;
			d    = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok = 1'b1;
			d    = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok = 1'b1;
			d    = c - 8'h57;
		end
		h.val = d[3:0];
		return h;
	endfunction

endpackage

`default_nettype wire

[rtl/fud_in_if.sv]
// Input channel of the form body decoder: one raw body byte per item.
// Standalone; no dependencies.
`default_nettype none

interface fud_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       body_end;

	modport source(output valid, in_byte, body_end, input ready);
	modport sink(input valid, in_byte, body_end, output ready);
endinterface

`default_nettype wire

[rtl/fud_out_if.sv]
// Result channel of the form body decoder: one decoded byte or pair end
// per item. Standalone; no dependencies.
`default_nettype none

interface fud_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       pair_kept;
	logic       run_last;

	modport source(output valid, out_byte, kind, pair_kept, run_last, input ready);
	modport sink(input valid, out_byte, kind, pair_kept, run_last, output ready);
endinterface

`default_nettype wire

[rtl/form_urlencoded_decoder.sv]
// Streaming decoder for a form-urlencoded body: '+' becomes a space, a '%'
// and two hex digits become one byte, '=' moves from key to value, and '&' or
// the final byte of the body closes a pair. A body byte is taken in every
// cycle while each byte gives at most one result and the output is ready; a
// byte giving n results (up to three in practice, when a held '%' sequence
// resolves or the body ends) holds the result register until all n are taken;
// the next byte waits only on that drain. A byte passes the input register,
// then the result register. No clearing pass: the decoder is ready right
// after reset. Uses fud_pkg, fud_in_if, fud_out_if, fud_step, fud_out_buf.
`default_nettype none

module form_urlencoded_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	fud_in_if.sink    body,
	fud_out_if.source result
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                advance;
	logic                can_load;
	logic                value_part_q;
	logic                key_seen_q;
	logic [1:0]          held_count_q;
	logic [7:0]          held_byte_q;
	fud_pkg::dec_state_t cur_state;
	fud_pkg::dec_state_t next_state;
	fud_pkg::res_set_t   res_set;

	assign advance    = valid_s1 && can_load;
	assign body.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			byte_s1 <= body.in_byte;
			end_s1  <= body.body_end;
		end
	end

	assign cur_state.value_part = value_part_q;
	assign cur_state.key_seen   = key_seen_q;
	assign cur_state.held_count = held_count_q;
	assign cur_state.held_byte  = held_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_part_q <= 1'b0;
			key_seen_q   <= 1'b0;
			held_count_q <= 2'd0;
		end else if (advance) begin
			value_part_q <= next_state.value_part;
			key_seen_q   <= next_state.key_seen;
			held_count_q <= next_state.held_count;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_byte_q <= next_state.held_byte;
		end
	end

	fud_step u_step (
		.state      (cur_state),
		.in_byte    (byte_s1),
		.body_end   (end_s1),
		.next_state (next_state),
		.res_set    (res_set)
	);

	fud_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res_set  (res_set),
		.can_load (can_load),
		.result   (result)
	);

endmodule

`default_nettype wire

[rtl/fud_step.sv]
// Decode logic for one body byte: resolves the held percent sequence,
// walks the key/value state and packs the results. Uses fud_pkg.
`default_nettype none

module fud_step (
	input  wire fud_pkg::dec_state_t state,
	input  wire logic [7:0]          in_byte,
	input  wire logic                body_end,
	output fud_pkg::dec_state_t      next_state,
	output fud_pkg::res_set_t        res_set
);

	typedef struct packed {
		logic       en;
		logic       lit;
		logic [7:0] data;
	} step_t;

	typedef struct packed {
		logic             valid;
		fud_pkg::result_t r;
	} cand_t;

	localparam int NumSteps = 4;
	localparam int NumCand  = NumSteps + 1;

	always_comb begin
		step_t                       st [NumSteps];
		cand_t                       cand [NumCand];
		logic [1:0]                  hc;
		logic [7:0]                  h1;
		logic                        ivp;
		logic                        ks;
		fud_pkg::hex_t               hx_a;
		fud_pkg::hex_t               hx_b;
		logic [fud_pkg::ResCntW-1:0] cnt;
		logic [fud_pkg::ResCntW-1:0] last_idx;

		for (int i = 0; i < NumSteps; i++) begin
			st[i] = '0;
		end
		hc   = state.held_count;
		h1   = state.held_byte;
		hx_a = fud_pkg::hex_digit(state.held_byte);
		hx_b = fud_pkg::hex_digit(in_byte);

		if (!state.held_count[1]) begin
			if (state.held_count == 2'd0) begin
				if (in_byte == fud_pkg::CharPct) begin
					hc = 2'd1;
				end else begin
					st[0] = {1'b1, 1'b0, in_byte};
				end
			end else begin
				h1 = in_byte;
				hc = 2'd2;
			end
		end else begin
			hc = 2'd0;
			if (hx_a.ok && hx_b.ok) begin
				st[0] = {1'b1, 1'b1, hx_a.val, hx_b.val};
			end else if (state.held_byte == fud_pkg::CharPct) begin
				// held byte opens a new sequence; this byte becomes its first digit
				h1 = in_byte;
				hc = 2'd2;
			end else begin
				st[0] = {1'b1, 1'b0, state.held_byte};
				if (in_byte == fud_pkg::CharPct) begin
					hc = 2'd1;
				end else begin
					st[1] = {1'b1, 1'b0, in_byte};
				end
			end
		end

		// body ends with a sequence still open: flush it literally
		if (body_end) begin
			st[2] = {hc != 2'd0, 1'b1, fud_pkg::CharPct};
			st[3] = {hc[1], 1'b0, h1};
			hc    = 2'd0;
		end

		ivp = state.value_part;
		ks  = state.key_seen;
		for (int i = 0; i < NumSteps; i++) begin
			cand[i] = '0;
			if (st[i].en) begin
				if (!st[i].lit && st[i].data == fud_pkg::CharEq) begin
					ivp = 1'b1;
				end else if (!st[i].lit && st[i].data == fud_pkg::CharAmp) begin
					cand[i].valid       = 1'b1;
					cand[i].r.kind      = fud_pkg::KIND_PAIR_END;
					cand[i].r.pair_kept = ks;
					ks  = 1'b0;
					ivp = 1'b0;
				end else begin
					cand[i].valid      = 1'b1;
					cand[i].r.out_byte = (!st[i].lit && st[i].data == fud_pkg::CharPlus)
						? fud_pkg::CharSpace : st[i].data;
					cand[i].r.kind     = ivp ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
					if (!ivp) begin
						ks = 1'b1;
					end
				end
			end
		end

		cand[NumSteps] = '0;
		if (body_end) begin
			cand[NumSteps].valid       = 1'b1;
			cand[NumSteps].r.kind      = fud_pkg::KIND_PAIR_END;
			cand[NumSteps].r.pair_kept = ks;
			ks  = 1'b0;
			ivp = 1'b0;
		end

		// pack valid results from slot 0, then mark the final one
		res_set.res = '0;
		cnt         = '0;
		for (int i = 0; i < NumCand; i++) begin
			if (cand[i].valid && cnt < fud_pkg::ResCntW'(fud_pkg::MaxResults)) begin
				res_set.res[cnt[fud_pkg::ResIdxW-1:0]] = cand[i].r;
				cnt = cnt + 1'b1;
			end
		end
		last_idx = cnt - 1'b1;
		if (cnt != '0) begin
			res_set.res[last_idx[fud_pkg::ResIdxW-1:0]].run_last = 1'b1;
		end
		res_set.count = cnt;

		next_state.value_part = ivp;
		next_state.key_seen   = ks;
		next_state.held_count = hc;
		next_state.held_byte  = h1;
	end

endmodule

`default_nettype wire

[rtl/fud_out_buf.sv]
// Result register: holds the results of one byte and hands them out one
// item per cycle while result.ready is high. Uses fud_pkg and fud_out_if.
`default_nettype none

module fud_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire fud_pkg::res_set_t res_set,
	output logic                   can_load,
	fud_out_if.source              result
);

	fud_pkg::result_t                entries_q [fud_pkg::MaxResults];
	logic [fud_pkg::ResCntW-1:0]     rem_q;
	logic [fud_pkg::ResIdxW-1:0]     rd_q;
	logic                            fire;

	assign fire     = result.valid && result.ready;
	assign can_load = (rem_q == '0) || (rem_q == fud_pkg::ResCntW'(1) && result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			rem_q <= res_set.count;
			rd_q  <= '0;
		end else if (fire) begin
			rem_q <= rem_q - 1'b1;
			rd_q  <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < fud_pkg::MaxResults; i++) begin
				entries_q[i] <= res_set.res[i];
			end
		end
	end

	assign result.valid     = (rem_q != '0);
	assign result.out_byte  = entries_q[rd_q].out_byte;
	assign result.kind      = entries_q[rd_q].kind;
	assign result.pair_kept = entries_q[rd_q].pair_kept;
	assign result.run_last  = entries_q[rd_q].run_last;

endmodule

`default_nettype wire
